@@ sv/mhsf_pkg.sv @@
// Package for the hard-iron sphere-fit block: widths, limits, register map,
// state and datapath command types. No dependencies.
`default_nettype none
package mhsf_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int COUNT_WIDTH  = 16;

  localparam int CTR_W     = 20;   // stored center, signed Q16
  localparam int RAD_W     = 20;
  localparam int LR_W      = 16;
  localparam int WARM_W    = 10;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam int DMAG_W  = 20;     // |sample - center| for an in-range sample
  localparam int SQ_W    = 42;     // sum of squares, also the shared product register
  localparam int ROOT_W  = 21;
  localparam int REM_W   = 24;
  localparam int NUM_W   = 41;     // R*|d| + dist/2
  localparam int QUO_W   = 21;
  localparam int DREM_W  = 21;
  localparam int SMAG_W  = 21;
  localparam int DELTA_W = 22;
  localparam int NC_W    = 24;
  localparam int ITER_N  = 21;     // sqrt and divide steps
  localparam int CNT_W   = 5;

  localparam int LIMIT_IN     = 655360;
  localparam int LIMIT_CENTER = 327680;
  localparam int MIN_DIST     = 66;
  localparam int ROUND_HALF   = 32768;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LRATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 2'd2;

  localparam logic [RAD_W-1:0]  RADIUS_RST = 20'd32768;
  localparam logic [LR_W-1:0]   LRATE_RST  = 16'd655;
  localparam logic [WARM_W-1:0] WARMUP_RST = 10'd50;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQ, OP_SQRT_INIT, OP_SQRT, OP_RMUL,
    OP_DIV_INIT, OP_DIV, OP_LMUL, OP_UPD, OP_FINISH
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT_INIT, S_SQRT, S_RMUL, S_DIV_INIT, S_DIV,
    S_LMUL, S_UPD, S_FIN
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic dist_ok;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ sv/mhsf_if.sv @@
// Valid/ready channel interfaces for samples in and results out.
// Depends on mhsf_pkg.
`default_nettype none
interface mhsf_in_if import mhsf_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_WIDTH-1:0]  mag_x;
  logic signed [SAMPLE_WIDTH-1:0]  mag_y;
  logic signed [SAMPLE_WIDTH-1:0]  mag_z;
  modport source (output valid, mag_x, mag_y, mag_z, input ready);
  modport sink   (input valid, mag_x, mag_y, mag_z, output ready);
endinterface

interface mhsf_out_if import mhsf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CTR_W-1:0]  bias_x;
  logic signed [CTR_W-1:0]  bias_y;
  logic signed [CTR_W-1:0]  bias_z;
  logic                     sample_used;
  logic                     center_cleared;
  logic                     warmed_up;
  modport source (output valid, bias_x, bias_y, bias_z, sample_used, center_cleared,
                  warmed_up, input ready);
  modport sink   (input valid, bias_x, bias_y, bias_z, sample_used, center_cleared,
                  warmed_up, output ready);
endinterface
`default_nettype wire

@@ sv/mhsf_dp.sv @@
// Datapath: center and count state, shared multiplier, iterative square root
// and divider, result registers. Depends on mhsf_pkg.
`default_nettype none
module mhsf_dp import mhsf_pkg::*; (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire dp_cmd_t                        cmd_i,
  output dp_sts_t                             sts_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] mag_x_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] mag_y_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] mag_z_i,
  input  wire logic [RAD_W-1:0]               radius_i,
  input  wire logic [LR_W-1:0]                lrate_i,
  input  wire logic [WARM_W-1:0]              warmup_i,
  output logic signed [CTR_W-1:0]             bias_x_o,
  output logic signed [CTR_W-1:0]             bias_y_o,
  output logic signed [CTR_W-1:0]             bias_z_o,
  output logic                                used_o,
  output logic                                cleared_o,
  output logic                                warm_o
);

  logic signed [CTR_W-1:0]  ctr_q [3];
  logic [COUNT_WIDTH-1:0]   count_q;

  logic [DMAG_W-1:0]        dmag_q [3];
  logic                     dneg_q [3];
  logic                     in_range_q;
  logic [SQ_W-1:0]          prod_q, acc_q, rad_q;
  logic [REM_W-1:0]         rem_q;
  logic [ROOT_W-1:0]        root_q;
  logic [DREM_W-1:0]        drem_q;
  logic [QUO_W-1:0]         numlo_q, quo_q;
  logic                     sneg_q;
  logic signed [CTR_W-1:0]  nc_q [3];
  logic                     clr_q;
  logic signed [CTR_W-1:0]  bias_q [3];
  logic                     used_q, cleared_q, warm_q;

  // Sample capture: range check and difference to the center.
  logic signed [SAMPLE_WIDTH-1:0] smp [3];
  logic signed [SAMPLE_WIDTH:0]   ext_v [3];
  logic signed [SAMPLE_WIDTH:0]   diff_v [3];
  logic [SAMPLE_WIDTH:0]          absm_v [3];
  logic [SAMPLE_WIDTH:0]          absd_v [3];
  logic                           rng_ok;

  assign smp[0] = mag_x_i;
  assign smp[1] = mag_y_i;
  assign smp[2] = mag_z_i;

  always_comb begin
    rng_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      ext_v[a]  = {smp[a][SAMPLE_WIDTH-1], smp[a]};
      diff_v[a] = ext_v[a] - {{(SAMPLE_WIDTH+1-CTR_W){ctr_q[a][CTR_W-1]}}, ctr_q[a]};
      absm_v[a] = ext_v[a][SAMPLE_WIDTH] ? -ext_v[a] : ext_v[a];
      absd_v[a] = diff_v[a][SAMPLE_WIDTH] ? -diff_v[a] : diff_v[a];
      if (absm_v[a] > (SAMPLE_WIDTH+1)'(LIMIT_IN)) rng_ok = 1'b0;
    end
  end

  // Square root step
  logic [REM_W+1:0] sq_sh, sq_trial;
  assign sq_sh    = {rem_q, rad_q[SQ_W-1 -: 2]};
  assign sq_trial = (REM_W+2)'({root_q, 2'b01});

  // Divide
  logic [NUM_W-1:0]  num_v;
  logic [DREM_W:0]   dv_sh;
  assign num_v = prod_q[NUM_W-1:0] + NUM_W'(root_q >> 1);
  assign dv_sh = {drem_q, numlo_q[QUO_W-1]};

  // Step magnitude and sign: |d| and the rounded quotient share the sign of d.
  logic [SMAG_W-1:0] dm_v, smag_v;
  logic              sneg_v;
  assign dm_v   = SMAG_W'(dmag_q[cmd_i.axis]);
  assign smag_v = (dm_v >= quo_q) ? dm_v - quo_q : quo_q - dm_v;
  assign sneg_v = dneg_q[cmd_i.axis] ^ (quo_q > dm_v);

  // Center update
  logic [LR_W+SMAG_W+1:0]  rnd_v;
  logic [DELTA_W-1:0]      dmg_v;
  logic signed [NC_W-1:0]  delta_v, nc_v;
  logic [NC_W-1:0]         ncabs_v;
  assign rnd_v   = {prod_q[LR_W+SMAG_W-1:0], 1'b0} + (LR_W+SMAG_W+1)'(ROUND_HALF);
  assign dmg_v   = rnd_v[16 +: DELTA_W];
  assign delta_v = sneg_q ? -NC_W'(dmg_v) : NC_W'(dmg_v);
  assign nc_v    = {{(NC_W-CTR_W){ctr_q[cmd_i.axis][CTR_W-1]}}, ctr_q[cmd_i.axis]} + delta_v;
  assign ncabs_v = nc_v[NC_W-1] ? -nc_v : nc_v;

  // Commit
  logic                     ok_v, warm_v;
  logic [COUNT_WIDTH-1:0]   cnt_v;
  logic signed [CTR_W-1:0]  ctr_v [3];
  assign ok_v = in_range_q && sts_o.dist_ok;
  always_comb begin
    cnt_v = count_q;
    for (int a = 0; a < 3; a++) ctr_v[a] = ctr_q[a];
    if (ok_v) begin
      if (count_q != '1) cnt_v = count_q + 1'b1;
      for (int a = 0; a < 3; a++) ctr_v[a] = clr_q ? '0 : nc_q[a];
    end
  end
  assign warm_v = cnt_v >= COUNT_WIDTH'(warmup_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) ctr_q[a] <= '0;
      count_q <= '0;
    end else if (cmd_i.op == OP_FINISH) begin
      for (int a = 0; a < 3; a++) ctr_q[a] <= ctr_v[a];
      count_q <= cnt_v;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        for (int a = 0; a < 3; a++) begin
          dmag_q[a] <= absd_v[a][DMAG_W-1:0];
          dneg_q[a] <= diff_v[a][SAMPLE_WIDTH];
        end
        in_range_q <= rng_ok;
        acc_q      <= '0;
        prod_q     <= '0;
        clr_q      <= 1'b0;
      end
      OP_SQ: begin
        acc_q  <= acc_q + prod_q;
        prod_q <= SQ_W'(dmag_q[cmd_i.axis] * dmag_q[cmd_i.axis]);
      end
      OP_SQRT_INIT: begin
        rad_q  <= acc_q + prod_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      OP_SQRT: begin
        rad_q <= rad_q << 2;
        if (sq_sh >= sq_trial) begin
          rem_q  <= REM_W'(sq_sh - sq_trial);
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= sq_sh[REM_W-1:0];
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      OP_RMUL: prod_q <= SQ_W'(radius_i * dmag_q[cmd_i.axis]);
      OP_DIV_INIT: begin
        drem_q  <= DREM_W'(num_v[NUM_W-1:QUO_W]);
        numlo_q <= num_v[QUO_W-1:0];
        quo_q   <= '0;
      end
      OP_DIV: begin
        numlo_q <= numlo_q << 1;
        if (dv_sh >= (DREM_W+1)'(root_q)) begin
          drem_q <= DREM_W'(dv_sh - (DREM_W+1)'(root_q));
          quo_q  <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          drem_q <= dv_sh[DREM_W-1:0];
          quo_q  <= {quo_q[QUO_W-2:0], 1'b0};
        end
      end
      OP_LMUL: begin
        prod_q <= SQ_W'(lrate_i * smag_v);
        sneg_q <= sneg_v;
      end
      OP_UPD: begin
        nc_q[cmd_i.axis] <= nc_v[CTR_W-1:0];
        if (ncabs_v > NC_W'(LIMIT_CENTER)) clr_q <= 1'b1;
      end
      OP_FINISH: begin
        for (int a = 0; a < 3; a++) bias_q[a] <= warm_v ? ctr_v[a] : '0;
        used_q    <= ok_v;
        cleared_q <= ok_v && clr_q;
        warm_q    <= warm_v;
      end
      default: ;
    endcase
  end

  assign sts_o.in_range = in_range_q;
  assign sts_o.dist_ok  = root_q >= ROOT_W'(MIN_DIST);

  assign bias_x_o  = bias_q[0];
  assign bias_y_o  = bias_q[1];
  assign bias_z_o  = bias_q[2];
  assign used_o    = used_q;
  assign cleared_o = cleared_q;
  assign warm_o    = warm_q;

endmodule
`default_nettype wire

@@ sv/mhsf_ctrl.sv @@
// Controller: sequences load, sum of squares, root, per-axis divide and update.
// Owns the handshakes. Depends on mhsf_pkg.
`default_nettype none
module mhsf_ctrl import mhsf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [1:0]        axis_q, axis_d;
  logic              ovld_q, ovld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      axis_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
      ovld_q  <= ovld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    axis_d     = axis_q;
    ovld_d     = ovld_q && !out_ready_i;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.axis = axis_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          cnt_d    = '0;
          axis_d   = '0;
          state_d  = S_SQ;
        end
      end
      S_SQ: begin
        if (!sts_i.in_range) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op   = OP_SQ;
          cmd_o.axis = cnt_q[1:0];
          cnt_d      = cnt_q + 1'b1;
          if (cnt_q == CNT_W'(2)) state_d = S_SQRT_INIT;
        end
      end
      S_SQRT_INIT: begin
        cmd_o.op = OP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ITER_N - 1)) state_d = S_RMUL;
      end
      S_RMUL: begin
        if (!sts_i.dist_ok) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_RMUL;
          state_d  = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ITER_N - 1)) state_d = S_LMUL;
      end
      S_LMUL: begin
        cmd_o.op = OP_LMUL;
        state_d  = S_UPD;
      end
      S_UPD: begin
        cmd_o.op = OP_UPD;
        axis_d   = axis_q + 1'b1;
        state_d  = (axis_q == 2'd2) ? S_FIN : S_RMUL;
      end
      S_FIN: begin
        // hold until the result register is free
        if (!ovld_q || out_ready_i) begin
          cmd_o.op = OP_FINISH;
          ovld_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = ovld_q;

endmodule
`default_nettype wire

@@ sv/mag_hard_iron_sphere_fit.sv @@
// Hard-iron sphere fit top level. An accepted sample runs the sum of squares, the 21-step
// root, and per axis a multiply, a 21-step divide, a multiply and an update; an out-of-range
// sample goes straight to the finish, one too close to the center stops after the root.
// Samples are taken one at a time, each once the previous one is finished; an output stall
// holds the finish, though a new sample is taken while the previous result beat still waits.
// Reset (async, active low) clears center, count and handshakes, loads register defaults.
`default_nettype none
module mag_hard_iron_sphere_fit import mhsf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mhsf_in_if.sink                    in_i,
  mhsf_out_if.source                 res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i
);

  // Configuration registers; writes to unknown indexes drop.
  logic [RAD_W-1:0]  radius_q;
  logic [LR_W-1:0]   lrate_q;
  logic [WARM_W-1:0] warmup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      lrate_q  <= LRATE_RST;
      warmup_q <= WARMUP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RADIUS: radius_q <= cfg_wdata_i[RAD_W-1:0];
        CFG_LRATE:  lrate_q  <= cfg_wdata_i[LR_W-1:0];
        CFG_WARMUP: warmup_q <= cfg_wdata_i[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller: sequences one sample at a time and owns the beat handshakes.
  mhsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: the sample fields are sampled on the load command only.
  mhsf_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .mag_x_i   (in_i.mag_x),
    .mag_y_i   (in_i.mag_y),
    .mag_z_i   (in_i.mag_z),
    .radius_i  (radius_q),
    .lrate_i   (lrate_q),
    .warmup_i  (warmup_q),
    .bias_x_o  (res_o.bias_x),
    .bias_y_o  (res_o.bias_y),
    .bias_z_o  (res_o.bias_z),
    .used_o    (res_o.sample_used),
    .cleared_o (res_o.center_cleared),
    .warm_o    (res_o.warmed_up)
  );

  // A rejected sample never reports a cleared center.
  a_clear_needs_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.sample_used) |-> !res_o.center_cleared)
    else $error("center_cleared without sample_used");

  // Bias stays zero until warmup is reached.
  a_bias_zero_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.warmed_up) |->
      (res_o.bias_x == '0 && res_o.bias_y == '0 && res_o.bias_z == '0))
    else $error("nonzero bias before warmup");

  // Reported bias is inside the 5 G clamp.
  a_bias_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.bias_x <= CTR_W'(LIMIT_CENTER) &&
                     res_o.bias_x >= -CTR_W'(LIMIT_CENTER) &&
                     res_o.bias_y <= CTR_W'(LIMIT_CENTER) &&
                     res_o.bias_y >= -CTR_W'(LIMIT_CENTER) &&
                     res_o.bias_z <= CTR_W'(LIMIT_CENTER) &&
                     res_o.bias_z >= -CTR_W'(LIMIT_CENTER)))
    else $error("bias beyond center limit");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bench for the hard-iron sphere-fit block: directed and random samples,
// register settings and handshake idling. Depends on mhsf_pkg, mhsf_if and the block.
module testbench;
  import mhsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Index that maps to no register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic signed [CTR_W-1:0] bias_x;
    logic signed [CTR_W-1:0] bias_y;
    logic signed [CTR_W-1:0] bias_z;
    logic                    sample_used;
    logic                    center_cleared;
    logic                    warmed_up;
  } bias_beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_W-1:0]      cfg_wdata;

  mhsf_in_if  smp_if ();
  mhsf_out_if res_if ();

  mag_hard_iron_sphere_fit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (smp_if.sink),
    .res_o       (res_if.source),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Shadow of the block: registers, center estimate and accepted count.
  longint             radius_q16;
  longint             lrate_q16;
  longint             warmup_n;
  longint             center_q16 [3];
  longint             used_count;

  bias_beat_t         bias_expected [$];
  int                 idle_pct;
  int                 stall_pct;
  int                 errors = 0;
  int                 beats_sent = 0;
  int                 beats_checked = 0;
  int                 n_used = 0;
  int                 n_cleared = 0;
  int                 quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Nearest with ties away from zero; den is positive.
  function automatic longint round_div(longint num, longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // Advance the shadow center by one sample and return the beat it must produce.
  function automatic bias_beat_t fit_step(logic signed [SAMPLE_WIDTH-1:0] mx,
                                          logic signed [SAMPLE_WIDTH-1:0] my,
                                          logic signed [SAMPLE_WIDTH-1:0] mz);
    bias_beat_t b;
    longint m [3];
    longint d [3];
    longint nc [3];
    longint unsigned sq;
    longint dist_q16;
    longint stp;
    logic warm;
    m[0] = mx;
    m[1] = my;
    m[2] = mz;
    b.sample_used = 1'b0;
    b.center_cleared = 1'b0;
    if (m[0] <= LIMIT_IN && m[0] >= -LIMIT_IN && m[1] <= LIMIT_IN && m[1] >= -LIMIT_IN &&
        m[2] <= LIMIT_IN && m[2] >= -LIMIT_IN) begin
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = m[i] - center_q16[i];
        sq += longint'(d[i] * d[i]);
      end
      dist_q16 = floor_sqrt(sq);
      if (dist_q16 >= MIN_DIST) begin
        for (int i = 0; i < 3; i++) begin
          stp = d[i] - round_div(radius_q16 * d[i], dist_q16);
          nc[i] = center_q16[i] + round_div(2 * lrate_q16 * stp, 65536);
          if (nc[i] > LIMIT_CENTER || nc[i] < -LIMIT_CENTER) b.center_cleared = 1'b1;
        end
        for (int i = 0; i < 3; i++) center_q16[i] = b.center_cleared ? 0 : nc[i];
        if (used_count < (64'd1 << COUNT_WIDTH) - 1) used_count++;
        b.sample_used = 1'b1;
      end
    end
    warm = (used_count >= warmup_n);
    b.warmed_up = warm;
    b.bias_x = warm ? CTR_W'(center_q16[0]) : '0;
    b.bias_y = warm ? CTR_W'(center_q16[1]) : '0;
    b.bias_z = warm ? CTR_W'(center_q16[2]) : '0;
    return b;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d, want %0d (beat %0d)", field, got, want, beats_checked);
    errors++;
  endtask

  // Check result beats in order, then predict from sample beats taken at the same edge.
  always @(posedge clk_i) begin
    bias_beat_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (bias_expected.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = bias_expected.pop_front();
          if (res_if.bias_x !== want.bias_x) report_mismatch("bias_x", res_if.bias_x, want.bias_x);
          if (res_if.bias_y !== want.bias_y) report_mismatch("bias_y", res_if.bias_y, want.bias_y);
          if (res_if.bias_z !== want.bias_z) report_mismatch("bias_z", res_if.bias_z, want.bias_z);
          if (res_if.sample_used !== want.sample_used)
            report_mismatch("sample_used", res_if.sample_used, want.sample_used);
          if (res_if.center_cleared !== want.center_cleared)
            report_mismatch("center_cleared", res_if.center_cleared, want.center_cleared);
          if (res_if.warmed_up !== want.warmed_up)
            report_mismatch("warmed_up", res_if.warmed_up, want.warmed_up);
          n_used += want.sample_used;
          n_cleared += want.center_cleared;
        end
        beats_checked++;
      end
      if (smp_if.valid && smp_if.ready) begin
        bias_expected.push_back(fit_step(smp_if.mag_x, smp_if.mag_y, smp_if.mag_z));
        beats_sent++;
      end
    end
  end

  // Receiver back-pressure: stall on a random share of cycles.
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("** mag_hard_iron_sphere_fit: FAILED **");
      $finish;
    end
  end

  // Hold valid high back to back unless an idle gap is rolled.
  task automatic send_sample(longint x, longint y, longint z);
    if ($urandom_range(99) < idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.mag_x <= SAMPLE_WIDTH'(x);
    smp_if.mag_y <= SAMPLE_WIDTH'(y);
    smp_if.mag_z <= SAMPLE_WIDTH'(z);
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
  endtask

  // Drop valid and let every expected beat come back; the block is idle after.
  task automatic drain;
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (bias_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Leaves the write enable high; clear it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      CFG_RADIUS: radius_q16 = val & 20'hFFFFF;
      CFG_LRATE:  lrate_q16 = val & 20'h0FFFF;
      CFG_WARMUP: warmup_n = val & 20'h003FF;
      default: ;
    endcase
  endtask

  task automatic set_regs(longint r, longint lr, longint w);
    drain();
    write_reg(CFG_RADIUS, CFG_W'(r));
    write_reg(CFG_LRATE, CFG_W'(lr));
    write_reg(CFG_WARMUP, CFG_W'(w));
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly in-range axes, with boundary values and full-width noise mixed in.
  function automatic longint rand_axis();
    case ($urandom_range(19))
      0: return longint'($urandom);
      1: return $urandom_range(1) ? longint'(LIMIT_IN) : -longint'(LIMIT_IN);
      2: return $urandom_range(1) ? longint'(LIMIT_IN) + 1 : -longint'(LIMIT_IN) - 1;
      3: return longint'($urandom_range(200)) - 100;
      default: return longint'($urandom_range(2 * LIMIT_IN)) - LIMIT_IN;
    endcase
  endfunction

  task automatic test_directed;
    idle_pct = 0;
    stall_pct = 0;
    // Reset defaults: tiny samples near the zero center, some too close to it.
    send_sample(0, 0, 0);
    send_sample(65, 0, 0);
    send_sample(66, 0, 0);
    send_sample(0, 0, -66);
    // Axis limits: exactly 10 G is fine, one LSB past it is not.
    send_sample(LIMIT_IN, -LIMIT_IN, LIMIT_IN);
    send_sample(LIMIT_IN + 1, 0, 0);
    send_sample(0, -LIMIT_IN - 1, 0);
    send_sample(0, 0, 24'sh7FFFFF);
    send_sample(24'sh800000, 24'sh800000, 24'sh800000);
    send_sample(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    // Unmapped register index must not disturb anything.
    drain();
    write_reg(CFG_UNMAPPED, 20'hFFFFF);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    send_sample(32768, 0, 0);
    // Zero warmup and full step with no radius: the center jumps past 5 G and clears.
    set_regs(0, 65535, 0);
    send_sample(LIMIT_IN, 0, 0);
    send_sample(-LIMIT_IN, LIMIT_IN, -LIMIT_IN);
    send_sample(100000, -50000, 20000);
    send_sample(-3000, 2000, 1000);
    // Largest radius and zero step: nothing moves.
    set_regs(655360, 0, 1023);
    send_sample(LIMIT_IN, LIMIT_IN, LIMIT_IN);
    send_sample(-200000, 100000, 0);
    // Largest radius with a strong step pushes the center outward.
    set_regs(655360, 65535, 1);
    send_sample(1000, 0, 0);
    send_sample(0, -1000, 500);
    send_sample(-LIMIT_IN, 0, 0);
  endtask

  task automatic test_random(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
  endtask

  task automatic test_random_settings(int n, int idle, int stall);
    set_regs($urandom_range(655360), $urandom_range(65535), $urandom_range(60));
    test_random(n, idle, stall);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    smp_if.valid = 1'b0;
    smp_if.mag_x = '0;
    smp_if.mag_y = '0;
    smp_if.mag_z = '0;
    idle_pct = 0;
    stall_pct = 0;
    radius_q16 = RADIUS_RST;
    lrate_q16 = LRATE_RST;
    warmup_n = WARMUP_RST;
    used_count = 0;
    for (int i = 0; i < 3; i++) center_q16[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    // Realistic field strength, modest step, and each idling mode in turn.
    set_regs(32768, 655, 50);
    test_random(100, 0, 0);
    test_random(80, 76, 0);
    test_random(80, 0, 76);
    test_random(60, 14, 14);
    // Hold off until everything has returned, then continue with fresh settings.
    drain();
    test_random_settings(50, 0, 0);
    test_random_settings(40, 14, 14);
    set_regs(655360, 65535, 0);
    test_random(20, 0, 76);
    set_regs(0, 1, 1023);
    test_random(20, 76, 0);

    drain();
    $display("covered %0d samples: %0d used, %0d center clears, %0d beats checked",
             beats_sent, n_used, n_cleared, beats_checked);
    if (errors == 0) begin
      $display("** mag_hard_iron_sphere_fit: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** mag_hard_iron_sphere_fit: FAILED **");
    end
    $finish;
  end

endmodule
